### design/line_pair_score_assert.svh
// Assertion macros for the line pair scorer checker.
`ifndef LINE_PAIR_SCORE_ASSERT_SVH
`define LINE_PAIR_SCORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LPS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("line_pair_score: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LPS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("line_pair_score: next-cycle check failed");

`endif

### design/lps_pkg.sv
// Shared constants, types and tables of the line pair scorer.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    localparam int COORD_BITS      = 11;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int ANGLE_W      = 8 + ANGLE_FRAC_BITS;
    localparam int LEN_W        = 2 * COORD_BITS + 1;
    localparam int FINE_FRAC    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int PRESHIFT     = 24;
    localparam int CX_W         = COORD_BITS + PRESHIFT + 3;
    localparam int Z_W          = 24;
    localparam int FINE_W       = Z_W + 1;
    localparam int RND_SH       = FINE_FRAC - ANGLE_FRAC_BITS;

    localparam int BETA_W = 16;
    localparam int AVG_W  = 48;
    localparam int MAP_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam int SCORE_W = 58;

    // back end widths
    localparam int SUM_W   = ANGLE_W + 1;
    localparam int MAP2_W  = MAP_W + 1;
    localparam int OFFS_W  = ((SUM_W > MAP2_W) ? SUM_W : MAP2_W) + 1;
    localparam int OFF_W   = OFFS_W - 1;
    localparam int DPROD_W = OFF_W + SUM_W;
    localparam int D_W     = DPROD_W - 2 * ANGLE_FRAC_BITS;
    localparam int LS_W    = LEN_W + 1;
    localparam int LSQ_W   = 2 * LS_W;
    localparam int T_W     = ((LSQ_W > AVG_W) ? LSQ_W : AVG_W) + 2;
    localparam int MAG_W   = T_W - 1;
    localparam int BFRAC   = 8;
    localparam int MH_W    = MAG_W - BFRAC;
    localparam int MH_LO_W = 24;
    localparam int MH_HI_W = MH_W - MH_LO_W;
    localparam int PROD_W  = BETA_W + MH_W + 1;
    localparam int P_W     = SCORE_W + 1;
    localparam int S_W     = P_W + 1;

    localparam int FRONT_LAT = CORDIC_STEPS + 3;
    localparam int BACK_LAT  = 9;

    localparam int MID_DEPTH = 32;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 32;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
    localparam int FCNT_W    = $clog2(FRONT_LAT + 1);
    localparam int BCNT_W    = $clog2(BACK_LAT + 1);

    localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(256);
    localparam logic [AVG_W-1:0]  AVG_RESET  = '0;
    localparam logic [MAP_W-1:0]  MAP_RESET  = MAP_W'(90 << ANGLE_FRAC_BITS);

    localparam logic [ANGLE_W-1:0] ANGLE_90   = ANGLE_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [ANGLE_W-1:0] ANGLE_WRAP = ANGLE_W'(180 << ANGLE_FRAC_BITS);
    localparam logic [SUM_W-1:0]   ANGLE_TOL  = SUM_W'(10 << ANGLE_FRAC_BITS);

    localparam logic signed [Z_W-1:0] NINETY_FINE = Z_W'(90 << FINE_FRAC);
    localparam logic [FINE_W-1:0] ONE_EIGHTY_FINE = FINE_W'(180 << FINE_FRAC);
    localparam logic [FINE_W-1:0] RND_HALF = FINE_W'(1 << (RND_SH - 1));
    localparam logic [FINE_W-1:0] WRAP_Q   = FINE_W'(180 << ANGLE_FRAC_BITS);

    localparam logic [SCORE_W-1:0] SCORE_MAX_U = SCORE_W'((64'd1 << (SCORE_W - 1)) - 1);
    localparam logic signed [S_W-1:0] SAT_MAX = S_W'((64'sd1 <<< (SCORE_W - 1)) - 1);
    localparam logic signed [S_W-1:0] SAT_MIN = -(S_W'((64'sd1 <<< (SCORE_W - 1))));
    localparam logic signed [SCORE_W-1:0] REJECT_SCORE = SCORE_W'(-10000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BETA = 2'd0,
        CFG_AVG  = 2'd1,
        CFG_MAP  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [BETA_W-1:0] beta;
        logic [AVG_W-1:0]  avg;
        logic [MAP_W-1:0]  map;
    } cfg_t;

    typedef struct packed {
        logic             vert;
        logic             horiz;
        logic             down;
        logic [LEN_W-1:0] len;
    } seg_flag_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_a;
        logic [ANGLE_W-1:0] angle_b;
        logic [LEN_W-1:0]   len_a;
        logic [LEN_W-1:0]   len_b;
    } seg_pair_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      rejected;
        seg_pair_t                 pair;
    } result_t;

    // atan(2^-i) in degrees with FINE_FRAC fraction bits
    function automatic logic signed [Z_W-1:0] atan_q16(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = Z_W'(2949120);
            1:  v = Z_W'(1740967);
            2:  v = Z_W'(919879);
            3:  v = Z_W'(466945);
            4:  v = Z_W'(234379);
            5:  v = Z_W'(117304);
            6:  v = Z_W'(58666);
            7:  v = Z_W'(29335);
            8:  v = Z_W'(14668);
            9:  v = Z_W'(7334);
            10: v = Z_W'(3667);
            11: v = Z_W'(1833);
            12: v = Z_W'(917);
            13: v = Z_W'(458);
            14: v = Z_W'(229);
            15: v = Z_W'(115);
            16: v = Z_W'(57);
            17: v = Z_W'(29);
            18: v = Z_W'(14);
            19: v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/lps_front.sv
// Front end: segment deltas, squared lengths and CORDIC headings, two lanes.
`timescale 1ns / 1ps
`default_nettype none

module lps_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [lps_pkg::COORD_BITS-1:0] a_x_start,
    input  logic [lps_pkg::COORD_BITS-1:0] a_y_start,
    input  logic [lps_pkg::COORD_BITS-1:0] a_x_end,
    input  logic [lps_pkg::COORD_BITS-1:0] a_y_end,
    input  logic [lps_pkg::COORD_BITS-1:0] b_x_start,
    input  logic [lps_pkg::COORD_BITS-1:0] b_y_start,
    input  logic [lps_pkg::COORD_BITS-1:0] b_x_end,
    input  logic [lps_pkg::COORD_BITS-1:0] b_y_end,
    output logic                           out_valid,
    output lps_pkg::seg_pair_t             out_data
);
    import lps_pkg::*;

    logic [COORD_BITS-1:0] xs [2];
    logic [COORD_BITS-1:0] ys [2];
    logic [COORD_BITS-1:0] xe [2];
    logic [COORD_BITS-1:0] ye [2];
    logic [ANGLE_W-1:0]    ang_reg [2];
    logic [LEN_W-1:0]      len_reg [2];
    logic [FRONT_LAT-1:0]  vld_reg;

    assign xs[0] = a_x_start;
    assign ys[0] = a_y_start;
    assign xe[0] = a_x_end;
    assign ye[0] = a_y_end;
    assign xs[1] = b_x_start;
    assign ys[1] = b_y_start;
    assign xe[1] = b_x_end;
    assign ye[1] = b_y_end;

    // advance the valid line; the datapath runs free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic signed [COORD_BITS:0]   dx_reg;
        logic signed [COORD_BITS:0]   dy_reg;
        logic [COORD_BITS-1:0]        ax;
        logic [COORD_BITS-1:0]        ay;
        logic [2*COORD_BITS-1:0]      sqx;
        logic [2*COORD_BITS-1:0]      sqy;
        seg_flag_t                    flag_next;
        logic signed [CX_W-1:0]       cx_reg [CORDIC_STEPS+1];
        logic signed [CX_W-1:0]       cy_reg [CORDIC_STEPS+1];
        logic signed [Z_W-1:0]        cz_reg [CORDIC_STEPS+1];
        seg_flag_t                    fl_reg [CORDIC_STEPS+1];
        logic signed [Z_W-1:0]        zc;
        logic [FINE_W-1:0]            fine;
        logic [FINE_W-1:0]            rnd;
        logic [ANGLE_W-1:0]           ang_next;

        // form the deltas, y measured upward
        always_ff @(posedge clk)
        begin
            dx_reg <= $signed({1'b0, xe[g]}) - $signed({1'b0, xs[g]});
            dy_reg <= $signed({1'b0, ys[g]}) - $signed({1'b0, ye[g]});
        end

        // classify and fold the direction into the first quadrant
        assign ax  = dx_reg[COORD_BITS] ? COORD_BITS'(-dx_reg) : COORD_BITS'(dx_reg);
        assign ay  = dy_reg[COORD_BITS] ? COORD_BITS'(-dy_reg) : COORD_BITS'(dy_reg);
        assign sqx = ax * ax;
        assign sqy = ay * ay;

        always_comb
        begin
            flag_next.vert  = (dx_reg == '0);
            flag_next.horiz = (dy_reg == '0);
            flag_next.down  = dx_reg[COORD_BITS] ? (!dy_reg[COORD_BITS] && dy_reg != '0)
                                                 : dy_reg[COORD_BITS];
            flag_next.len   = {1'b0, sqx} + {1'b0, sqy};
        end

        always_ff @(posedge clk)
        begin
            cx_reg[0] <= CX_W'({ax, {PRESHIFT{1'b0}}});
            cy_reg[0] <= CX_W'({ay, {PRESHIFT{1'b0}}});
            cz_reg[0] <= '0;
            fl_reg[0] <= flag_next;
        end

        // one vectoring rotation per stage
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
            always_ff @(posedge clk)
            begin
                if (!cy_reg[k][CX_W-1])
                begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    cz_reg[k+1] <= cz_reg[k] + atan_q16(k);
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    cz_reg[k+1] <= cz_reg[k] - atan_q16(k);
                end
                fl_reg[k+1] <= fl_reg[k];
            end
        end

        // clamp, mirror downward directions, round and wrap
        always_comb
        begin
            if (cz_reg[CORDIC_STEPS][Z_W-1])
                zc = '0;
            else if (cz_reg[CORDIC_STEPS] > NINETY_FINE)
                zc = NINETY_FINE;
            else
                zc = cz_reg[CORDIC_STEPS];
            fine = fl_reg[CORDIC_STEPS].down ? (ONE_EIGHTY_FINE - FINE_W'(zc))
                                             : FINE_W'(zc);
            rnd  = (fine + RND_HALF) >> RND_SH;
            if (fl_reg[CORDIC_STEPS].vert)
                ang_next = ANGLE_90;
            else if (fl_reg[CORDIC_STEPS].horiz)
                ang_next = '0;
            else if (rnd >= WRAP_Q)
                ang_next = '0;
            else
                ang_next = rnd[ANGLE_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            ang_reg[g] <= ang_next;
            len_reg[g] <= fl_reg[CORDIC_STEPS].len;
        end
    end

    assign out_valid        = vld_reg[FRONT_LAT-1];
    assign out_data.angle_a = ang_reg[0];
    assign out_data.angle_b = ang_reg[1];
    assign out_data.len_a   = len_reg[0];
    assign out_data.len_b   = len_reg[1];

endmodule

`default_nettype wire

### design/lps_mid_q.sv
// Queue of classified segment pairs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module lps_mid_q (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  lps_pkg::seg_pair_t         wdata,
    input  logic                       pop,
    output lps_pkg::seg_pair_t         rdata,
    output logic                       empty,
    output logic [lps_pkg::MID_CW-1:0] count
);
    import lps_pkg::*;

    seg_pair_t           mem_reg [MID_DEPTH];
    logic [MID_AW-1:0]   wr_ptr_reg;
    logic [MID_AW-1:0]   rd_ptr_reg;
    logic [MID_CW-1:0]   cnt_reg;
    logic [MID_CW-1:0]   cnt_next;

    // store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // track pointers and fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

`default_nettype wire

### design/lps_back.sv
// Back end: angle term, squared length sum and saturated weighted score.
`timescale 1ns / 1ps
`default_nettype none

module lps_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  lps_pkg::seg_pair_t in_data,
    input  lps_pkg::cfg_t      cfg,
    output logic               out_valid,
    output lps_pkg::result_t   out_data
);
    import lps_pkg::*;

    logic [BACK_LAT-1:0] vld_reg;
    seg_pair_t           pair_reg [BACK_LAT];

    logic [SUM_W-1:0]          sum1_reg;
    logic signed [SUM_W-1:0]   dif1_reg;
    logic [LS_W-1:0]           ls1_reg;

    logic signed [OFFS_W-1:0]  offs;
    logic [SUM_W-1:0]          adif;
    logic                      far2_reg;
    logic [OFF_W-1:0]          off2_reg;
    logic [SUM_W-1:0]          sum2_reg;
    logic [LS_W-1:0]           ls2_reg;

    logic [DPROD_W-1:0]        dprod;
    logic [D_W-1:0]            d3_reg;
    logic [LSQ_W-1:0]          lsq3_reg;

    logic signed [T_W-1:0]     t4_reg;
    logic                      rej4_reg;
    logic [D_W-1:0]            d4_reg;

    logic                      neg5_reg;
    logic [MAG_W-1:0]          mag5_reg;
    logic                      rej5_reg;
    logic [D_W-1:0]            d5_reg;

    logic [MH_W-1:0]           mh;
    logic [BETA_W+BFRAC-1:0]   pfull;
    logic [BETA_W+MH_LO_W-1:0] plo6_reg;
    logic [BETA_W+MH_HI_W-1:0] phi6_reg;
    logic [BETA_W-1:0]         pf6_reg;
    logic                      neg6_reg;
    logic                      rej6_reg;
    logic [D_W-1:0]            d6_reg;

    logic [PROD_W-1:0]         prod7_reg;
    logic                      neg7_reg;
    logic                      rej7_reg;
    logic [D_W-1:0]            d7_reg;

    logic [SCORE_W-1:0]        pc;
    logic signed [P_W-1:0]     p8_reg;
    logic                      rej8_reg;
    logic [D_W-1:0]            d8_reg;

    logic signed [S_W-1:0]     s9;
    logic signed [SCORE_W-1:0] score_next;
    logic signed [SCORE_W-1:0] score9_reg;
    logic                      rej9_reg;

    // advance the valid line; the datapath runs free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[BACK_LAT-2:0], in_valid};
    end

    // carry the segment fields alongside the score
    always_ff @(posedge clk)
    begin
        pair_reg[0] <= in_data;
        for (int i = 1; i < BACK_LAT; i++)
            pair_reg[i] <= pair_reg[i-1];
    end

    // stage 1: angle sum, angle difference, length sum
    always_ff @(posedge clk)
    begin
        sum1_reg <= SUM_W'(in_data.angle_a) + SUM_W'(in_data.angle_b);
        dif1_reg <= $signed(SUM_W'(in_data.angle_a)) - $signed(SUM_W'(in_data.angle_b));
        ls1_reg  <= LS_W'(in_data.len_a) + LS_W'(in_data.len_b);
    end

    // stage 2: closeness test and offset from twice the map heading
    assign offs = $signed(OFFS_W'(sum1_reg)) - $signed(OFFS_W'({cfg.map, 1'b0}));
    assign adif = dif1_reg[SUM_W-1] ? SUM_W'(-dif1_reg) : SUM_W'(dif1_reg);

    always_ff @(posedge clk)
    begin
        far2_reg <= (adif > ANGLE_TOL);
        off2_reg <= offs[OFFS_W-1] ? OFF_W'(-offs) : OFF_W'(offs);
        sum2_reg <= sum1_reg;
        ls2_reg  <= ls1_reg;
    end

    // stage 3: angle term truncated to whole degrees squared, length square
    assign dprod = off2_reg * sum2_reg;

    always_ff @(posedge clk)
    begin
        d3_reg   <= far2_reg ? dprod[DPROD_W-1:2*ANGLE_FRAC_BITS] : '0;
        lsq3_reg <= ls2_reg * ls2_reg;
    end

    // stage 4: inner term
    always_ff @(posedge clk)
    begin
        t4_reg   <= $signed(T_W'(lsq3_reg)) - $signed(T_W'(cfg.avg)) - $signed(T_W'(d3_reg));
        rej4_reg <= (d3_reg == '0);
        d4_reg   <= d3_reg;
    end

    // stage 5: sign and magnitude
    always_ff @(posedge clk)
    begin
        neg5_reg <= t4_reg[T_W-1];
        mag5_reg <= t4_reg[T_W-1] ? MAG_W'(-t4_reg) : MAG_W'(t4_reg);
        rej5_reg <= rej4_reg;
        d5_reg   <= d4_reg;
    end

    // stage 6: partial products of beta and the magnitude
    assign mh    = mag5_reg[MAG_W-1:BFRAC];
    assign pfull = cfg.beta * mag5_reg[BFRAC-1:0];

    always_ff @(posedge clk)
    begin
        plo6_reg <= cfg.beta * mh[MH_LO_W-1:0];
        phi6_reg <= cfg.beta * mh[MH_W-1:MH_LO_W];
        pf6_reg  <= pfull[BETA_W+BFRAC-1:BFRAC];
        neg6_reg <= neg5_reg;
        rej6_reg <= rej5_reg;
        d6_reg   <= d5_reg;
    end

    // stage 7: combine partial products
    always_ff @(posedge clk)
    begin
        prod7_reg <= (PROD_W'(phi6_reg) << MH_LO_W) + PROD_W'(plo6_reg) + PROD_W'(pf6_reg);
        neg7_reg  <= neg6_reg;
        rej7_reg  <= rej6_reg;
        d7_reg    <= d6_reg;
    end

    // stage 8: clamp magnitude and restore the sign
    assign pc = (prod7_reg > PROD_W'(SCORE_MAX_U)) ? SCORE_MAX_U : prod7_reg[SCORE_W-1:0];

    always_ff @(posedge clk)
    begin
        p8_reg   <= neg7_reg ? -$signed({1'b0, pc}) : $signed({1'b0, pc});
        rej8_reg <= rej7_reg;
        d8_reg   <= d7_reg;
    end

    // stage 9: add the angle term, saturate, substitute the reject score
    always_comb
    begin
        s9 = $signed({p8_reg[P_W-1], p8_reg}) + $signed(S_W'(d8_reg));
        if (rej8_reg)
            score_next = REJECT_SCORE;
        else if (s9 > SAT_MAX)
            score_next = SAT_MAX[SCORE_W-1:0];
        else if (s9 < SAT_MIN)
            score_next = SAT_MIN[SCORE_W-1:0];
        else
            score_next = s9[SCORE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        score9_reg <= score_next;
        rej9_reg   <= rej8_reg;
    end

    assign out_valid         = vld_reg[BACK_LAT-1];
    assign out_data.score    = score9_reg;
    assign out_data.rejected = rej9_reg;
    assign out_data.pair     = pair_reg[BACK_LAT-1];

endmodule

`default_nettype wire

### design/lps_out_q.sv
// Result queue presenting finished scores to the consumer.
`timescale 1ns / 1ps
`default_nettype none

module lps_out_q (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  lps_pkg::result_t           wdata,
    input  logic                       pop,
    output lps_pkg::result_t           rdata,
    output logic                       empty,
    output logic [lps_pkg::OUT_CW-1:0] count
);
    import lps_pkg::*;

    result_t             mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]   wr_ptr_reg;
    logic [OUT_AW-1:0]   rd_ptr_reg;
    logic [OUT_CW-1:0]   cnt_reg;
    logic [OUT_CW-1:0]   cnt_next;

    // store the finished transaction
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // track pointers and fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

`default_nettype wire

### design/line_pair_score.sv
// A pair passes 23 front stages, the first clocked at the accepting edge, one write into the
// middle queue, where it waits while the back end does not draw, 9 back stages and one write
// into the output queue before it heads that queue; the earliest pop is at the following edge.
// Throughput: one pair per cycle while full is low; full rises when the middle queue plus the
// front pairs reach 32; the back end stops drawing when the 32-entry output queue is spoken for.
// Reset: asynchronous, active low; clears queues and valid lines, beta 1.0, map 90 degrees.
`timescale 1ns / 1ps
`default_nettype none

module line_pair_score (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [lps_pkg::COORD_BITS-1:0]        a_x_start,
    input  logic [lps_pkg::COORD_BITS-1:0]        a_y_start,
    input  logic [lps_pkg::COORD_BITS-1:0]        a_x_end,
    input  logic [lps_pkg::COORD_BITS-1:0]        a_y_end,
    input  logic [lps_pkg::COORD_BITS-1:0]        b_x_start,
    input  logic [lps_pkg::COORD_BITS-1:0]        b_y_start,
    input  logic [lps_pkg::COORD_BITS-1:0]        b_x_end,
    input  logic [lps_pkg::COORD_BITS-1:0]        b_y_end,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [lps_pkg::SCORE_W-1:0]    pair_score,
    output logic                                  rejected,
    output logic [lps_pkg::ANGLE_W-1:0]           angle_a,
    output logic [lps_pkg::ANGLE_W-1:0]           angle_b,
    output logic [lps_pkg::LEN_W-1:0]             length_sq_a,
    output logic [lps_pkg::LEN_W-1:0]             length_sq_b,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import lps_pkg::*;

    localparam int MCRED_W = MID_CW + 1;
    localparam int OCRED_W = OUT_CW + 1;

    cfg_t               cfg_reg;
    logic               accept;
    logic               front_vld;
    seg_pair_t          front_data;
    seg_pair_t          mid_data;
    logic               mid_empty;
    logic [MID_CW-1:0]  mid_count;
    logic               back_go;
    logic               back_vld;
    result_t            back_data;
    result_t            head;
    logic               out_empty;
    logic [OUT_CW-1:0]  out_count;
    logic               out_pop;
    logic [FCNT_W-1:0]  fcnt_reg;
    logic [FCNT_W-1:0]  fcnt_next;
    logic [BCNT_W-1:0]  bcnt_reg;
    logic [BCNT_W-1:0]  bcnt_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beta <= BETA_RESET;
            cfg_reg.avg  <= AVG_RESET;
            cfg_reg.map  <= MAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BETA: cfg_reg.beta <= cfg_data[BETA_W-1:0];
                CFG_AVG:  cfg_reg.avg  <= cfg_data[AVG_W-1:0];
                CFG_MAP:  cfg_reg.map  <= cfg_data[MAP_W-1:0];
                default:  ;
            endcase
        end
    end

    // hold off input while middle queue space is already promised
    assign full    = (MCRED_W'(mid_count) + MCRED_W'(fcnt_reg)) >= MCRED_W'(MID_DEPTH);
    assign accept  = push && !full;
    assign back_go = !mid_empty
                     && ((OCRED_W'(out_count) + OCRED_W'(bcnt_reg)) < OCRED_W'(OUT_DEPTH));
    assign out_pop = pop && !out_empty;

    // count pairs in flight through each pipeline
    always_comb
    begin
        fcnt_next = fcnt_reg + FCNT_W'(accept) - FCNT_W'(front_vld);
        bcnt_next = bcnt_reg + BCNT_W'(back_go) - BCNT_W'(back_vld);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
            bcnt_reg <= '0;
        end
        else
        begin
            fcnt_reg <= fcnt_next;
            bcnt_reg <= bcnt_next;
        end
    end

    lps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a_x_start (a_x_start),
        .a_y_start (a_y_start),
        .a_x_end   (a_x_end),
        .a_y_end   (a_y_end),
        .b_x_start (b_x_start),
        .b_y_start (b_y_start),
        .b_x_end   (b_x_end),
        .b_y_end   (b_y_end),
        .out_valid (front_vld),
        .out_data  (front_data)
    );

    lps_mid_q u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_vld),
        .wdata (front_data),
        .pop   (back_go),
        .rdata (mid_data),
        .empty (mid_empty),
        .count (mid_count)
    );

    lps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (back_go),
        .in_data   (mid_data),
        .cfg       (cfg_reg),
        .out_valid (back_vld),
        .out_data  (back_data)
    );

    lps_out_q u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_vld),
        .wdata (back_data),
        .pop   (out_pop),
        .rdata (head),
        .empty (out_empty),
        .count (out_count)
    );

    assign empty       = out_empty;
    assign pair_score  = head.score;
    assign rejected    = head.rejected;
    assign angle_a     = head.pair.angle_a;
    assign angle_b     = head.pair.angle_b;
    assign length_sq_a = head.pair.len_a;
    assign length_sq_b = head.pair.len_b;

endmodule

`default_nettype wire

### design/lps_checker.sv
// Port-level checker for the line pair scorer and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "line_pair_score_assert.svh"

module lps_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               empty,
    input wire logic                               pop,
    input wire logic signed [lps_pkg::SCORE_W-1:0] pair_score,
    input wire logic                               rejected,
    input wire logic [lps_pkg::ANGLE_W-1:0]        angle_a,
    input wire logic [lps_pkg::ANGLE_W-1:0]        angle_b
);
    import lps_pkg::*;

    // a rejected pair always carries the sentinel score
    `LPS_ASSERT_IMPL(a_reject_score, clk, rst_n, !empty && rejected, pair_score == REJECT_SCORE)
    // headings stay below 180 degrees
    `LPS_ASSERT_IMPL(a_angle_range, clk, rst_n, !empty, angle_a < ANGLE_WRAP && angle_b < ANGLE_WRAP)
    // a waiting result is not withdrawn
    `LPS_ASSERT_NEXT(a_hold_valid, clk, rst_n, !empty && !pop, !empty)
    // a waiting result does not change
    `LPS_ASSERT_NEXT(a_hold_score, clk, rst_n, !empty && !pop, $stable(pair_score))

endmodule

bind line_pair_score lps_checker u_lps_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .pair_score (pair_score),
    .rejected   (rejected),
    .angle_a    (angle_a),
    .angle_b    (angle_b)
);

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the line pair scorer: directed table, then random pairs.
`timescale 1ns / 1ps

module tb_top;
    import lps_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  RAND_PER_CFG = 225;
    localparam longint SAT_HI = (64'sd1 <<< (SCORE_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint REJECT_VAL = -10000000;

    typedef struct {
        logic [COORD_BITS-1:0] axs, ays, axe, aye, bxs, bys, bxe, bye;
    } pair_t;

    typedef struct {
        logic signed [SCORE_W-1:0] score;
        logic                      rej;
        logic [ANGLE_W-1:0]        ang_a, ang_b;
        logic [LEN_W-1:0]          len_a, len_b;
    } score_t;

    typedef struct {
        pair_t  p;
        bit     typed;
        score_t want;
    } table_row_t;

    logic clk, rst_n;
    logic push, pop, full, empty;
    logic [COORD_BITS-1:0] a_x_start, a_y_start, a_x_end, a_y_end;
    logic [COORD_BITS-1:0] b_x_start, b_y_start, b_x_end, b_y_end;
    logic signed [SCORE_W-1:0] pair_score;
    logic rejected;
    logic [ANGLE_W-1:0] angle_a, angle_b;
    logic [LEN_W-1:0] length_sq_a, length_sq_b;
    logic cfg_valid, cfg_ready;
    cfg_idx_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the registers
    longint unsigned beta_q, avg_q, map_q;

    score_t pending_scores[$];
    int     error_count;
    int     cycle_count;
    int     send_idle_pct, recv_stall_pct;
    logic   holding;
    bit     cur_typed;
    score_t cur_want;

    longint atan_tab[CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    line_pair_score DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Heading of x>0, y>=0 in degrees, 16 fraction bits, clamped to [0,90]
    function automatic longint vector_heading(longint x, longint y);
        longint z, nx, ny;
        z = 0;
        x = x <<< PRESHIFT;
        y = y <<< PRESHIFT;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) <<< FINE_FRAC)) z = longint'(90) <<< FINE_FRAC;
        return z;
    endfunction

    task automatic segment_heading(input logic [COORD_BITS-1:0] xs, ys, xe, ye,
                                   output longint ang, output longint len);
        longint dx, dy, fine, q;
        dx = longint'(xe) - longint'(xs);
        dy = longint'(ys) - longint'(ye);
        len = dx * dx + dy * dy;
        if (dx == 0)
        begin
            ang = longint'(90) <<< ANGLE_FRAC_BITS;
            return;
        end
        if (dx < 0)
        begin
            dx = -dx;
            dy = -dy;
        end
        if (dy == 0)
        begin
            ang = 0;
            return;
        end
        if (dy > 0)
            fine = vector_heading(dx, dy);
        else
            fine = (longint'(180) <<< FINE_FRAC) - vector_heading(dx, -dy);
        q = (fine + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
        if (q >= (longint'(180) <<< ANGLE_FRAC_BITS)) q = 0;
        ang = q;
    endtask

    task automatic score_pair(input pair_t p, output score_t r);
        longint aa, ab, la, lb, d, diff, sum, off, ls, t, pv, sc;
        longint unsigned mag, prod;
        segment_heading(p.axs, p.ays, p.axe, p.aye, aa, la);
        segment_heading(p.bxs, p.bys, p.bxe, p.bye, ab, lb);
        d = 0;
        diff = (aa > ab) ? aa - ab : ab - aa;
        if (diff > (longint'(10) <<< ANGLE_FRAC_BITS))
        begin
            sum = aa + ab;
            off = sum - 2 * longint'(map_q);
            if (off < 0) off = -off;
            d = (off * sum) >>> (2 * ANGLE_FRAC_BITS);
        end
        if (d == 0)
            sc = REJECT_VAL;
        else
        begin
            ls = la + lb;
            t = ls * ls - longint'(avg_q) - d;
            mag = (t < 0) ? longint'(-t) : t;
            prod = beta_q * (mag >> 8) + ((beta_q * (mag & 255)) >> 8);
            if (prod > SAT_HI) prod = SAT_HI;
            pv = (t < 0) ? -longint'(prod) : longint'(prod);
            sc = pv + d;
            if (sc > SAT_HI) sc = SAT_HI;
            if (sc < SAT_LO) sc = SAT_LO;
        end
        r.score = sc[SCORE_W-1:0];
        r.rej   = (d == 0);
        r.ang_a = aa[ANGLE_W-1:0];
        r.ang_b = ab[ANGLE_W-1:0];
        r.len_a = la[LEN_W-1:0];
        r.len_b = lb[LEN_W-1:0];
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("ERROR cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    // Record the expected score of every accepted pair transaction
    always @(posedge clk)
    begin
        score_t r;
        if (rst_n && push && !full)
        begin
            if (cur_typed)
                r = cur_want;
            else
                score_pair('{a_x_start, a_y_start, a_x_end, a_y_end,
                             b_x_start, b_y_start, b_x_end, b_y_end}, r);
            pending_scores.push_back(r);
        end
    end

    // Check each popped result transaction and pick the next pop
    always @(posedge clk)
    begin
        score_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_scores.size() == 0)
                report_mismatch("unexpected result", pair_score, 0);
            else
            begin
                w = pending_scores.pop_front();
                if (pair_score !== w.score) report_mismatch("pair_score", pair_score, w.score);
                if (rejected !== w.rej) report_mismatch("rejected", rejected, w.rej);
                if (angle_a !== w.ang_a) report_mismatch("angle_a", angle_a, w.ang_a);
                if (angle_b !== w.ang_b) report_mismatch("angle_b", angle_b, w.ang_b);
                if (length_sq_a !== w.len_a)
                    report_mismatch("length_sq_a", length_sq_a, w.len_a);
                if (length_sq_b !== w.len_b)
                    report_mismatch("length_sq_b", length_sq_b, w.len_b);
            end
        end
        if (!rst_n || holding)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold off the receiver so the block backs up and raises full
    task automatic hold_receiver();
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BETA: beta_q = val[BETA_W-1:0];
            CFG_AVG:  avg_q  = val[AVG_W-1:0];
            CFG_MAP:  map_q  = val[MAP_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one pair transaction; returns at the edge that accepted it
    task automatic send_pair(pair_t p, bit typed, score_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        a_x_start <= p.axs;
        a_y_start <= p.ays;
        a_x_end   <= p.axe;
        a_y_end   <= p.aye;
        b_x_start <= p.bxs;
        b_y_start <= p.bys;
        b_x_end   <= p.bxe;
        b_y_end   <= p.bye;
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] c, int span);
        return c + COORD_BITS'($urandom_range(2 * span) - span);
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int kind;
        p = '{COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom)};
        kind = $urandom_range(9);
        // bias toward near-axis, short and degenerate segments
        case (kind)
            0: p.aye = near(p.ays, 3);
            1: p.axe = near(p.axs, 3);
            2: begin p.bxe = p.bxs; p.bye = near(p.bys, 2); end
            3: begin p.axe = near(p.axs, 20); p.aye = near(p.ays, 20); end
            4: begin p.bxe = near(p.axe, 8); p.bye = near(p.aye, 8);
                     p.bxs = near(p.axs, 8); p.bys = near(p.ays, 8); end
            default: ;
        endcase
        return p;
    endfunction

    function automatic score_t typed_reject(int ang_a, int ang_b, int la, int lb);
        score_t r;
        r.score = REJECT_VAL[SCORE_W-1:0];
        r.rej   = 1'b1;
        r.ang_a = ANGLE_W'(ang_a);
        r.ang_b = ANGLE_W'(ang_b);
        r.len_a = LEN_W'(la);
        r.len_b = LEN_W'(lb);
        return r;
    endfunction

    initial
    begin
        table_row_t rows[$];
        score_t none;
        logic [CFG_DATA_W-1:0] beta_set[4], avg_set[4], map_set[4];

        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BETA;
        cfg_data = '0;
        {a_x_start, a_y_start, a_x_end, a_y_end} = '0;
        {b_x_start, b_y_start, b_x_end, b_y_end} = '0;
        holding = 1'b0;
        cur_typed = 1'b0;
        cur_want = '{default: '0};
        none = '{default: '0};
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        beta_q = 256;
        avg_q = 0;
        map_q = 23040;

        // directed rows: zero length, horizontal, vertical at the extremes
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, typed_reject(23040, 23040, 0, 0)});
        rows.push_back('{'{0, 5, 2047, 5, 2047, 9, 0, 9}, 1,
                         typed_reject(0, 0, 4190209, 4190209)});
        rows.push_back('{'{2047, 0, 2047, 2047, 0, 2047, 0, 0}, 1,
                         typed_reject(23040, 23040, 4190209, 4190209)});
        rows.push_back('{'{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047}, 1,
                         typed_reject(23040, 23040, 0, 0)});
        // horizontal against vertical, diagonals in every direction, reversed ends
        rows.push_back('{'{0, 0, 2047, 0, 0, 0, 0, 2047}, 0, none});
        rows.push_back('{'{0, 2047, 2047, 0, 0, 0, 2047, 2047}, 0, none});
        rows.push_back('{'{2047, 0, 0, 2047, 2047, 2047, 0, 0}, 0, none});
        rows.push_back('{'{0, 1, 2047, 0, 0, 0, 2047, 1}, 0, none});
        rows.push_back('{'{100, 100, 200, 100, 100, 100, 200, 83}, 0, none});
        rows.push_back('{'{100, 100, 200, 100, 100, 100, 200, 81}, 0, none});
        rows.push_back('{'{10, 10, 11, 2047, 10, 10, 2047, 11}, 0, none});
        rows.push_back('{'{1024, 1024, 1023, 0, 5, 5, 4, 2047}, 0, none});
        rows.push_back('{'{0, 0, 1, 1, 0, 0, 2047, 1}, 0, none});
        rows.push_back('{'{2047, 1024, 0, 1023, 0, 1024, 2047, 1023}, 0, none});
        rows.push_back('{'{1365, 682, 682, 1365, 3, 3, 7, 0}, 0, none});
        rows.push_back('{'{2047, 2047, 0, 0, 2047, 0, 0, 2047}, 0, none});

        beta_set = '{256, 0, 16'hFFFF, 1};
        avg_set  = '{0, 0, 48'hFFFF_FFFF_FFFF, 48'd12345678901};
        map_set  = '{23040, 0, 46079, 16'hFFFF};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings
        foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].want);
        cur_typed <= 1'b0;
        for (int i = 0; i < 10; i++) send_pair(rows[i % 16].p, 0, none);
        push <= 1'b0;

        for (int c = 0; c < 4; c++)
        begin
            // drain before touching registers
            wait (pending_scores.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
            write_reg(CFG_BETA, beta_set[c]);
            write_reg(CFG_AVG, avg_set[c]);
            write_reg(CFG_MAP, map_set[c]);
            @(posedge clk);
            for (int ph = 0; ph < 4; ph++)
            begin
                case (ph)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                    default: begin send_idle_pct = 6; recv_stall_pct = 6; end
                endcase
                if (ph == 0 && (c == 0 || c == 2))
                    fork
                        hold_receiver();
                    join_none
                for (int k = 0; k < RAND_PER_CFG / 4; k++)
                    send_pair(random_pair(), 0, none);
            end
            push <= 1'b0;
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end

        // drain and settle
        wait (pending_scores.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
